// File: design/polygon_vertex_angle_stream_unit_defines.svh
// Assertion helpers shared by the RTL. Both use clk and rst_n of the enclosing module.
`ifndef POLYGON_VERTEX_ANGLE_STREAM_UNIT_DEFINES_SVH
`define POLYGON_VERTEX_ANGLE_STREAM_UNIT_DEFINES_SVH

// same-cycle implication
`define PVAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PVAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pvas_pkg.sv
`default_nettype none

package pvas_pkg;

  localparam int IDX_W       = 10;   // vertex_index
  localparam int ANG_W       = 9;    // angle_degrees
  localparam int FRAC_BITS   = 16;   // phi in 2^-16 degree
  localparam int PRESCALE    = 24;   // CORDIC operand prescale
  localparam int TABLE_LEN   = 24;
  localparam int Z_W         = 26;   // signed angle accumulator
  localparam int PHI_W       = 24;   // clamped phi, 0 .. 180 deg
  localparam int DEG_W       = 8;
  localparam int OUT_DEPTH   = 4;    // result buffer entries
  localparam int JOB_SLOTS   = 3;    // angle jobs one vertex can cause
  localparam int OUT_TDATA_W = 24;

  localparam logic signed [Z_W-1:0] PHI_90  = Z_W'(90 << FRAC_BITS);
  localparam logic signed [Z_W-1:0] PHI_180 = Z_W'(180 << FRAC_BITS);
  localparam logic [PHI_W:0]        CEIL_ADD = (PHI_W+1)'((1 << FRAC_BITS) - 1);
  localparam logic [ANG_W-1:0]      ANGLE_FULL = ANG_W'(360);

  localparam logic [DEG_W-1:0] DEG_0   = 8'd0;
  localparam logic [DEG_W-1:0] DEG_45  = 8'd45;
  localparam logic [DEG_W-1:0] DEG_90  = 8'd90;
  localparam logic [DEG_W-1:0] DEG_135 = 8'd135;
  localparam logic [DEG_W-1:0] DEG_180 = 8'd180;

  // travels beside each angle job down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             done;
    logic             degen;
    logic             cross_pos;
    logic             special;      // phi known exactly, CORDIC result ignored
    logic [DEG_W-1:0] special_deg;
  } pvas_tag_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [ANG_W-1:0] angle;
    logic             degen;
    logic             done;
  } pvas_result_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:    return Z_W'(2949120);
      5'd1:    return Z_W'(1740967);
      5'd2:    return Z_W'(919879);
      5'd3:    return Z_W'(466945);
      5'd4:    return Z_W'(234379);
      5'd5:    return Z_W'(117304);
      5'd6:    return Z_W'(58666);
      5'd7:    return Z_W'(29335);
      5'd8:    return Z_W'(14668);
      5'd9:    return Z_W'(7334);
      5'd10:   return Z_W'(3667);
      5'd11:   return Z_W'(1833);
      5'd12:   return Z_W'(917);
      5'd13:   return Z_W'(458);
      5'd14:   return Z_W'(229);
      5'd15:   return Z_W'(115);
      5'd16:   return Z_W'(57);
      5'd17:   return Z_W'(29);
      5'd18:   return Z_W'(14);
      5'd19:   return Z_W'(7);
      5'd20:   return Z_W'(4);
      5'd21:   return Z_W'(2);
      5'd22:   return Z_W'(1);
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: design/pvas_prep.sv
`default_nettype none

// Edge vectors, cross and dot, special angles and CORDIC start vector.
// Four register stages.
module pvas_prep #(
  parameter int COORD_BITS = 12,
  parameter int X_W        = 53
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [2*COORD_BITS-1:0]             vtx_p,
  input  logic [2*COORD_BITS-1:0]             vtx_c,
  input  logic [2*COORD_BITS-1:0]             vtx_n,
  input  pvas_pkg::pvas_tag_t                 tag_i,
  output logic                                out_valid,
  output logic signed [X_W-1:0]               x_o,
  output logic signed [X_W-1:0]               y_o,
  output logic signed [pvas_pkg::Z_W-1:0]     z_o,
  output pvas_pkg::pvas_tag_t                 tag_o
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int P_W   = 2 * D_W;
  localparam int S_W   = P_W + 1;
  localparam int EXT_W = X_W - S_W - pvas_pkg::PRESCALE;

  // stage A: edge vectors
  logic                  a_valid_r;
  logic signed [D_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [D_W-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt;
  pvas_pkg::pvas_tag_t   a_tag_r;

  assign ax_nxt = $signed({1'b0, vtx_p[COORD_BITS-1:0]}) - $signed({1'b0, vtx_c[COORD_BITS-1:0]});
  assign ay_nxt = $signed({1'b0, vtx_p[2*COORD_BITS-1:COORD_BITS]})
                - $signed({1'b0, vtx_c[2*COORD_BITS-1:COORD_BITS]});
  assign bx_nxt = $signed({1'b0, vtx_n[COORD_BITS-1:0]}) - $signed({1'b0, vtx_c[COORD_BITS-1:0]});
  assign by_nxt = $signed({1'b0, vtx_n[2*COORD_BITS-1:COORD_BITS]})
                - $signed({1'b0, vtx_c[2*COORD_BITS-1:COORD_BITS]});

  // stage B: products
  logic                  b_valid_r;
  logic signed [P_W-1:0] axby_r, aybx_r, axbx_r, ayby_r;
  logic signed [P_W-1:0] axby_nxt, aybx_nxt, axbx_nxt, ayby_nxt;
  pvas_pkg::pvas_tag_t   b_tag_r, b_tag_nxt;

  always_comb begin
    axby_nxt = P_W'(ax_r) * P_W'(by_r);
    aybx_nxt = P_W'(ay_r) * P_W'(bx_r);
    axbx_nxt = P_W'(ax_r) * P_W'(bx_r);
    ayby_nxt = P_W'(ay_r) * P_W'(by_r);
    b_tag_nxt = a_tag_r;
    b_tag_nxt.degen = ((ax_r == '0) && (ay_r == '0)) || ((bx_r == '0) && (by_r == '0));
  end

  // stage C: cross and dot
  logic                  c_valid_r;
  logic signed [S_W-1:0] cross_r, dot_r, cross_nxt, dot_nxt;
  pvas_pkg::pvas_tag_t   c_tag_r;

  assign cross_nxt = S_W'(axby_r) - S_W'(aybx_r);
  assign dot_nxt   = S_W'(axbx_r) + S_W'(ayby_r);

  // stage D: magnitudes, exact cases, start vector
  logic                               d_valid_r;
  logic signed [X_W-1:0]              x_r, y_r, x_nxt, y_nxt;
  logic signed [pvas_pkg::Z_W-1:0]    z_r, z_nxt;
  pvas_pkg::pvas_tag_t                d_tag_r, d_tag_nxt;
  logic signed [S_W-1:0]              acr, adot, neg_dot;
  logic                               dot_pos;

  always_comb begin
    neg_dot = -dot_r;
    acr     = cross_r[S_W-1] ? -cross_r : cross_r;
    adot    = dot_r[S_W-1] ? neg_dot : dot_r;
    dot_pos = !dot_r[S_W-1] && (dot_r != '0);

    d_tag_nxt             = c_tag_r;
    d_tag_nxt.cross_pos   = !cross_r[S_W-1] && (cross_r != '0);
    d_tag_nxt.special     = 1'b1;
    d_tag_nxt.special_deg = pvas_pkg::DEG_0;
    if (cross_r == '0) begin
      d_tag_nxt.special_deg = dot_pos ? pvas_pkg::DEG_0 : pvas_pkg::DEG_180;
    end else if (dot_r == '0) begin
      d_tag_nxt.special_deg = pvas_pkg::DEG_90;
    end else if (acr == adot) begin
      d_tag_nxt.special_deg = dot_pos ? pvas_pkg::DEG_45 : pvas_pkg::DEG_135;
    end else begin
      d_tag_nxt.special = 1'b0;
    end

    // left half plane is rotated by -90 deg first, with z starting at +90 deg
    if (!dot_r[S_W-1]) begin
      x_nxt = $signed({{EXT_W{1'b0}}, dot_r, {pvas_pkg::PRESCALE{1'b0}}});
      y_nxt = $signed({{EXT_W{1'b0}}, acr, {pvas_pkg::PRESCALE{1'b0}}});
      z_nxt = '0;
    end else begin
      x_nxt = $signed({{EXT_W{1'b0}}, acr, {pvas_pkg::PRESCALE{1'b0}}});
      y_nxt = $signed({{EXT_W{1'b0}}, neg_dot, {pvas_pkg::PRESCALE{1'b0}}});
      z_nxt = pvas_pkg::PHI_90;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    a_tag_r <= tag_i;
    axby_r  <= axby_nxt;
    aybx_r  <= aybx_nxt;
    axbx_r  <= axbx_nxt;
    ayby_r  <= ayby_nxt;
    b_tag_r <= b_tag_nxt;
    cross_r <= cross_nxt;
    dot_r   <= dot_nxt;
    c_tag_r <= b_tag_r;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    d_tag_r <= d_tag_nxt;
  end

  assign out_valid = d_valid_r;
  assign x_o       = x_r;
  assign y_o       = y_r;
  assign z_o       = z_r;
  assign tag_o     = d_tag_r;

endmodule

`default_nettype wire

// File: design/pvas_cell.sv
`default_nettype none

// One vectoring CORDIC iteration with a fixed shift of STAGE.
module pvas_cell #(
  parameter int X_W   = 53,
  parameter int STAGE = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic signed [X_W-1:0]           x_i,
  input  logic signed [X_W-1:0]           y_i,
  input  logic signed [pvas_pkg::Z_W-1:0] z_i,
  input  pvas_pkg::pvas_tag_t             tag_i,
  output logic                            out_valid,
  output logic signed [X_W-1:0]           x_o,
  output logic signed [X_W-1:0]           y_o,
  output logic signed [pvas_pkg::Z_W-1:0] z_o,
  output pvas_pkg::pvas_tag_t             tag_o
);

  localparam logic signed [pvas_pkg::Z_W-1:0] ATAN_Z = pvas_pkg::atan_entry(5'(STAGE));

  logic                            valid_r;
  logic signed [X_W-1:0]           x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [pvas_pkg::Z_W-1:0] z_r, z_nxt;
  pvas_pkg::pvas_tag_t             tag_r;

  always_comb begin
    dx = y_i >>> STAGE;   // arithmetic shift floors
    dy = x_i >>> STAGE;
    if (!y_i[X_W-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN_Z;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    tag_r <= tag_i;
  end

  assign out_valid = valid_r;
  assign x_o       = x_r;
  assign y_o       = y_r;
  assign z_o       = z_r;
  assign tag_o     = tag_r;

endmodule

`default_nettype wire

// File: design/pvas_finish.sv
`default_nettype none

// Clamp phi, pick exact value where known, turn into floored whole degrees.
module pvas_finish (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic signed [pvas_pkg::Z_W-1:0] z_i,
  input  pvas_pkg::pvas_tag_t             tag_i,
  output logic                            out_valid,
  output pvas_pkg::pvas_result_t          res_o
);

  localparam int PHI_W = pvas_pkg::PHI_W;
  localparam int FB    = pvas_pkg::FRAC_BITS;

  logic                          valid_r;
  pvas_pkg::pvas_result_t        res_r, res_nxt;
  logic [PHI_W-1:0]              phi;
  logic [PHI_W:0]                ceil_sum;
  logic [pvas_pkg::ANG_W-1:0]    ceil_deg;

  always_comb begin
    if (tag_i.special) begin
      phi = {tag_i.special_deg, {FB{1'b0}}};
    end else if (z_i[pvas_pkg::Z_W-1]) begin
      phi = '0;
    end else if (z_i > pvas_pkg::PHI_180) begin
      phi = pvas_pkg::PHI_180[PHI_W-1:0];
    end else begin
      phi = z_i[PHI_W-1:0];
    end
    ceil_sum = {1'b0, phi} + pvas_pkg::CEIL_ADD;
    ceil_deg = ceil_sum[PHI_W:FB];

    res_nxt.index = tag_i.index;
    res_nxt.degen = tag_i.degen;
    res_nxt.done  = tag_i.done;
    if (tag_i.degen) begin
      res_nxt.angle = '0;
    end else if (tag_i.cross_pos) begin
      res_nxt.angle = pvas_pkg::ANG_W'(phi[PHI_W-1:FB]);
    end else begin
      res_nxt.angle = pvas_pkg::ANGLE_FULL - ceil_deg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign res_o     = res_r;

endmodule

`default_nettype wire

// File: design/polygon_vertex_angle_stream_unit.sv
// Polygon vertex angle stream unit.
// Input: one vertex per word on in_*; in_tdata = {y, x}, in_tlast marks the closing
// vertex. Output: one angle per word on out_*; out_tdata = {pad, angle, index},
// out_tuser = zero-length edge flag, out_tlast = last angle of the polygon (vertex 0).
// A vertex from the third on gives the angle of the vertex before it; the closing
// vertex gives three angles (vertex n-2, n-1, then 0). Polygons under three
// vertices give nothing.
// Each angle runs a 4-stage cross/dot front end, a chain of CORDIC_STEPS iteration
// cells and one finishing stage; a closing vertex's three jobs issue one after
// another from slot 0. The chain takes one item at a time: a vertex that gives
// angles holds in_tready low until all of its jobs have left the finishing stage;
// vertices that give nothing leave in_tready high.
// A 4-word output buffer decouples out_tready: in_tready also waits until at most
// one word is still buffered, so a stalled receiver stalls the input, never drops.
// Reset (rst_n low, synchronous) empties the pipeline and buffer and clears the count.
`default_nettype none
`include "polygon_vertex_angle_stream_unit_defines.svh"

module polygon_vertex_angle_stream_unit #(
  parameter int COORD_BITS   = 12,
  parameter int MAX_VERTICES = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // slave side: vertex words
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     in_tdata,   // vertex_x, vertex_y
  input  logic                                  in_tlast,   // closes_polygon
  // master side: angle words
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pvas_pkg::OUT_TDATA_W-1:0]      out_tdata,  // vertex_index, angle_degrees
  output logic                                  out_tuser,  // degenerate_edge
  output logic                                  out_tlast   // polygon_done
);

  localparam int V_W    = 2 * COORD_BITS;
  localparam int CNT_W  = $clog2(MAX_VERTICES);
  localparam int IDX_W  = pvas_pkg::IDX_W;
  localparam int EXT_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int S_W    = 2 * (COORD_BITS + 1) + 1;
  localparam int X_W    = S_W + pvas_pkg::PRESCALE + 2;
  localparam int SLOTS  = pvas_pkg::JOB_SLOTS;
  localparam int JOB_W  = $clog2(SLOTS + 1);
  localparam int DEPTH  = pvas_pkg::OUT_DEPTH;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FCNT_W = $clog2(DEPTH + 1);
  localparam int PAD_W  = pvas_pkg::OUT_TDATA_W - IDX_W - pvas_pkg::ANG_W;

  logic             in_fire;
  logic [V_W-1:0]   vtx_in;

  // polygon state
  logic [V_W-1:0]   first_r, second_r, older_r, newest_r;
  logic [V_W-1:0]   first_nxt, second_nxt, older_nxt, newest_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [EXT_W-1:0] k_ext, km1_ext;

  // pending angle jobs, issued from slot 0
  logic [V_W-1:0]      slot_p_r [SLOTS];
  logic [V_W-1:0]      slot_c_r [SLOTS];
  logic [V_W-1:0]      slot_n_r [SLOTS];
  pvas_pkg::pvas_tag_t slot_tag_r [SLOTS];
  logic [V_W-1:0]      slot_p_nxt [SLOTS];
  logic [V_W-1:0]      slot_c_nxt [SLOTS];
  logic [V_W-1:0]      slot_n_nxt [SLOTS];
  pvas_pkg::pvas_tag_t slot_tag_nxt [SLOTS];
  logic [JOB_W-1:0]    jobs_left_r, jobs_left_nxt;
  logic [JOB_W-1:0]    inflight_r, inflight_nxt;
  logic                issue;

  // CORDIC chain
  logic                            ch_valid [CORDIC_STEPS+1];
  logic signed [X_W-1:0]           ch_x [CORDIC_STEPS+1];
  logic signed [X_W-1:0]           ch_y [CORDIC_STEPS+1];
  logic signed [pvas_pkg::Z_W-1:0] ch_z [CORDIC_STEPS+1];
  pvas_pkg::pvas_tag_t             ch_tag [CORDIC_STEPS+1];

  logic                   fin_valid;
  pvas_pkg::pvas_result_t fin_res;

  // output buffer
  pvas_pkg::pvas_result_t buf_r [DEPTH];
  pvas_pkg::pvas_result_t head;
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [FCNT_W-1:0]      fifo_cnt_r, fifo_cnt_nxt;
  logic                   fifo_rd;

  assign vtx_in    = in_tdata[V_W-1:0];
  assign in_tready = (jobs_left_r == '0) && (inflight_r == '0)
                   && (fifo_cnt_r <= FCNT_W'(DEPTH - SLOTS));
  assign in_fire   = in_tvalid && in_tready;
  assign issue     = (jobs_left_r != '0);
  assign k_ext     = EXT_W'(cnt_r);
  assign km1_ext   = k_ext - EXT_W'(1);

  always_comb begin
    first_nxt     = first_r;
    second_nxt    = second_r;
    older_nxt     = older_r;
    newest_nxt    = newest_r;
    cnt_nxt       = cnt_r;
    jobs_left_nxt = jobs_left_r;
    for (int j = 0; j < SLOTS; j++) begin
      slot_p_nxt[j]   = slot_p_r[j];
      slot_c_nxt[j]   = slot_c_r[j];
      slot_n_nxt[j]   = slot_n_r[j];
      slot_tag_nxt[j] = slot_tag_r[j];
    end

    if (issue) begin
      for (int j = 0; j < SLOTS - 1; j++) begin
        slot_p_nxt[j]   = slot_p_r[j+1];
        slot_c_nxt[j]   = slot_c_r[j+1];
        slot_n_nxt[j]   = slot_n_r[j+1];
        slot_tag_nxt[j] = slot_tag_r[j+1];
      end
      jobs_left_nxt = jobs_left_r - JOB_W'(1);
    end

    if (in_fire) begin
      if (in_tlast) begin
        if (cnt_r >= CNT_W'(2)) begin
          // vertex n-2, vertex n-1 wrapping to 0, vertex 0 wrapping from n-1
          slot_p_nxt[0] = older_r;
          slot_c_nxt[0] = newest_r;
          slot_n_nxt[0] = vtx_in;
          slot_tag_nxt[0] = '0;
          slot_tag_nxt[0].index = km1_ext[IDX_W-1:0];
          slot_p_nxt[1] = newest_r;
          slot_c_nxt[1] = vtx_in;
          slot_n_nxt[1] = first_r;
          slot_tag_nxt[1] = '0;
          slot_tag_nxt[1].index = k_ext[IDX_W-1:0];
          slot_p_nxt[2] = vtx_in;
          slot_c_nxt[2] = first_r;
          slot_n_nxt[2] = second_r;
          slot_tag_nxt[2] = '0;
          slot_tag_nxt[2].done = 1'b1;
          jobs_left_nxt = JOB_W'(SLOTS);
        end
        cnt_nxt = '0;
      end else begin
        if (cnt_r == '0) begin
          first_nxt = vtx_in;
        end else if (cnt_r == CNT_W'(1)) begin
          second_nxt = vtx_in;
        end else begin
          slot_p_nxt[0] = older_r;
          slot_c_nxt[0] = newest_r;
          slot_n_nxt[0] = vtx_in;
          slot_tag_nxt[0] = '0;
          slot_tag_nxt[0].index = km1_ext[IDX_W-1:0];
          jobs_left_nxt = JOB_W'(1);
        end
        older_nxt  = newest_r;
        newest_nxt = vtx_in;
        if (cnt_r < CNT_W'(MAX_VERTICES - 1)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end

    case ({issue, fin_valid})
      2'b10:   inflight_nxt = inflight_r + JOB_W'(1);
      2'b01:   inflight_nxt = inflight_r - JOB_W'(1);
      default: inflight_nxt = inflight_r;
    endcase

    case ({fin_valid, fifo_rd})
      2'b10:   fifo_cnt_nxt = fifo_cnt_r + FCNT_W'(1);
      2'b01:   fifo_cnt_nxt = fifo_cnt_r - FCNT_W'(1);
      default: fifo_cnt_nxt = fifo_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      second_r    <= '0;
      older_r     <= '0;
      newest_r    <= '0;
      cnt_r       <= '0;
      jobs_left_r <= '0;
      inflight_r  <= '0;
      fifo_cnt_r  <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
    end else begin
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      older_r     <= older_nxt;
      newest_r    <= newest_nxt;
      cnt_r       <= cnt_nxt;
      jobs_left_r <= jobs_left_nxt;
      inflight_r  <= inflight_nxt;
      fifo_cnt_r  <= fifo_cnt_nxt;
      if (fin_valid) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (fifo_rd) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SLOTS; j++) begin
      slot_p_r[j]   <= slot_p_nxt[j];
      slot_c_r[j]   <= slot_c_nxt[j];
      slot_n_r[j]   <= slot_n_nxt[j];
      slot_tag_r[j] <= slot_tag_nxt[j];
    end
    if (fin_valid) begin
      buf_r[wr_ptr_r] <= fin_res;
    end
  end

  // front end: edge vectors through CORDIC start vector
  pvas_prep #(
    .COORD_BITS (COORD_BITS),
    .X_W        (X_W)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue),
    .vtx_p     (slot_p_r[0]),
    .vtx_c     (slot_c_r[0]),
    .vtx_n     (slot_n_r[0]),
    .tag_i     (slot_tag_r[0]),
    .out_valid (ch_valid[0]),
    .x_o       (ch_x[0]),
    .y_o       (ch_y[0]),
    .z_o       (ch_z[0]),
    .tag_o     (ch_tag[0])
  );

  // one cell per iteration, each with its own shift and table entry
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
    pvas_cell #(
      .X_W   (X_W),
      .STAGE (s)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[s]),
      .x_i       (ch_x[s]),
      .y_i       (ch_y[s]),
      .z_i       (ch_z[s]),
      .tag_i     (ch_tag[s]),
      .out_valid (ch_valid[s+1]),
      .x_o       (ch_x[s+1]),
      .y_o       (ch_y[s+1]),
      .z_o       (ch_z[s+1]),
      .tag_o     (ch_tag[s+1])
    );
  end

  pvas_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ch_valid[CORDIC_STEPS]),
    .z_i       (ch_z[CORDIC_STEPS]),
    .tag_i     (ch_tag[CORDIC_STEPS]),
    .out_valid (fin_valid),
    .res_o     (fin_res)
  );

  // the final x, y of the chain are not needed: only the angle accumulator is
  assign head       = buf_r[rd_ptr_r];
  assign out_tvalid = (fifo_cnt_r != '0);
  assign fifo_rd    = out_tvalid && out_tready;
  assign out_tdata  = {{PAD_W{1'b0}}, head.angle, head.index};
  assign out_tuser  = head.degen;
  assign out_tlast  = head.done;

  `PVAS_ASSERT_IMP(a_buf_no_overflow, fin_valid && !fifo_rd, fifo_cnt_r != FCNT_W'(DEPTH), "result buffer overflow")
  `PVAS_ASSERT_IMP(a_result_was_issued, fin_valid, inflight_r != '0, "angle result with no job in flight")
  `PVAS_ASSERT_NXT(a_short_polygon_silent, in_fire && in_tlast && (cnt_r < CNT_W'(2)), (jobs_left_r == '0) && (cnt_r == '0), "short polygon queued angle jobs")
  `PVAS_ASSERT_NXT(a_closing_three_jobs, in_fire && in_tlast && (cnt_r >= CNT_W'(2)), (jobs_left_r == JOB_W'(SLOTS)) && slot_tag_r[SLOTS-1].done, "closing vertex did not queue three jobs")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int STEPS     = 16;          // CORDIC iterations at the DUT default
  localparam int LAST_IDX  = 1023;        // vertex count saturates here
  localparam int LONG_HOLD = 300;         // receiver hold-off, in cycles
  localparam longint PHI_ONE  = 64'd1 << 16;
  localparam longint PHI_HALF = 64'd180 << 16;
  localparam longint ATAN_LUT [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // directed row: vertex, closing flag, optional typed-in angle and degen flag for the first word it causes
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
    logic        pin;
    logic [8:0]  pin_ang;
    logic        pin_deg;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [pvas_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic quiet_phase = 1'b0;
  logic sink_hold = 1'b0;

  // predictor state
  logic [23:0] poly_first, poly_second, poly_older, poly_newest;
  logic [9:0]  poly_count;

  pvas_pkg::pvas_result_t pending_angles [$];
  int mismatch_count = 0;
  int results_seen = 0;
  int vertices_sent = 0;
  int polygons_sent = 0;
  int degen_seen = 0;
  int top_index = 0;

  stim_row_t directed_rows [0:23] = '{
    // closing vertex straight after reset: nothing
    '{12'd0,    12'd0,    1'b1, 1'b0, 9'd0,   1'b0},
    // two-vertex polygon: nothing
    '{12'd5,    12'd5,    1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd10,   12'd10,   1'b1, 1'b0, 9'd0,   1'b0},
    // full-range square, one winding: corners read 270
    '{12'd0,    12'd0,    1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd4095, 12'd0,    1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd4095, 12'd4095, 1'b0, 1'b1, 9'd270, 1'b0},
    '{12'd0,    12'd4095, 1'b1, 1'b1, 9'd270, 1'b0},
    // same square, other winding: 90
    '{12'd0,    12'd0,    1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd0,    12'd4095, 1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd4095, 12'd4095, 1'b0, 1'b1, 9'd90,  1'b0},
    '{12'd4095, 12'd0,    1'b1, 1'b1, 9'd90,  1'b0},
    // straight line through vertex 1: 180
    '{12'd0,    12'd0,    1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd2048, 12'd2048, 1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd4095, 12'd4095, 1'b0, 1'b1, 9'd180, 1'b0},
    '{12'd4095, 12'd0,    1'b1, 1'b0, 9'd0,   1'b0},
    // |cross| == |dot|: 45
    '{12'd4095, 12'd0,    1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd0,    12'd0,    1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd4095, 12'd4095, 1'b1, 1'b1, 9'd45,  1'b0},
    // collinear spike: 360
    '{12'd10,   12'd10,   1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd20,   12'd20,   1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd10,   12'd10,   1'b1, 1'b1, 9'd360, 1'b0},
    // repeated vertex: zero-length edge
    '{12'd100,  12'd100,  1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd100,  12'd100,  1'b0, 1'b0, 9'd0,   1'b0},
    '{12'd200,  12'd300,  1'b1, 1'b1, 9'd0,   1'b1}
  };

  polygon_vertex_angle_stream_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // vectoring CORDIC, phi of (dot, |cross|) in 2^-16 degree
  function automatic longint cordic_phase(input longint dot_v, input longint mag_v);
    longint x, y, z, dx, dy;
    if (dot_v >= 0) begin
      x = dot_v <<< 24;
      y = mag_v <<< 24;
      z = 0;
    end else begin
      // rotate by -90 and start z at +90 so the vector sits in the right half-plane
      x = mag_v <<< 24;
      y = (-dot_v) <<< 24;
      z = 64'd90 << 16;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_LUT[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_LUT[i];
      end
    end
    return z;
  endfunction

  function automatic logic [8:0] vertex_angle_deg(input logic [23:0] p, c, n,
                                                  output logic degen);
    longint ax, ay, bx, by, cr, dt, acr, adt, phi;
    ax = longint'(p[11:0]) - longint'(c[11:0]);
    ay = longint'(p[23:12]) - longint'(c[23:12]);
    bx = longint'(n[11:0]) - longint'(c[11:0]);
    by = longint'(n[23:12]) - longint'(c[23:12]);
    degen = 1'b0;
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
      degen = 1'b1;
      return 9'd0;
    end
    cr  = ax * by - ay * bx;
    dt  = ax * bx + ay * by;
    acr = (cr < 0) ? -cr : cr;
    adt = (dt < 0) ? -dt : dt;
    // exact multiples of 45 bypass the CORDIC
    if (cr == 0)
      phi = (dt > 0) ? 0 : PHI_HALF;
    else if (dt == 0)
      phi = 64'd90 << 16;
    else if (acr == adt)
      phi = ((dt > 0) ? 64'd45 : 64'd135) << 16;
    else
      phi = cordic_phase(dt, acr);
    if (phi < 0) phi = 0;
    if (phi > PHI_HALF) phi = PHI_HALF;
    if (cr > 0)
      return 9'(phi >>> 16);
    return 9'(360 - ((phi + PHI_ONE - 1) >>> 16));
  endfunction

  function automatic pvas_pkg::pvas_result_t angle_word(input logic [9:0] idx,
                                                        input logic [23:0] p, c, n,
                                                        input logic done);
    pvas_pkg::pvas_result_t r;
    logic dg;
    r.angle = vertex_angle_deg(p, c, n, dg);
    r.index = idx;
    r.degen = dg;
    r.done  = done;
    return r;
  endfunction

  function automatic logic [11:0] pick_coord(input int mode);
    case (mode)
      0:       return 12'($urandom_range(0, 4095));
      1:       return 12'($urandom_range(0, 3) * 1365);  // coarse grid: collinear, 45s
      2:       return 12'($urandom_range(0, 2));         // tiny: repeats, short edges
      default: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
    endcase
  endfunction

  // offer one vertex word, wait for acceptance, then predict what it causes
  task automatic send_vertex(input logic [11:0] x, y, input logic last,
                             input logic pin, input logic [8:0] pin_ang,
                             input logic pin_deg);
    pvas_pkg::pvas_result_t words [0:2];
    logic [23:0] v;
    int nw;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);

    v  = {y, x};
    nw = 0;
    if (last) begin
      if (poly_count >= 2) begin
        words[0] = angle_word(poly_count - 10'd1, poly_older, poly_newest, v, 1'b0);
        words[1] = angle_word(poly_count, poly_newest, v, poly_first, 1'b0);
        words[2] = angle_word(10'd0, v, poly_first, poly_second, 1'b1);
        nw = 3;
      end
      poly_count = '0;
      polygons_sent++;
    end else begin
      if (poly_count == 0)
        poly_first = v;
      else if (poly_count == 1)
        poly_second = v;
      else begin
        words[0] = angle_word(poly_count - 10'd1, poly_older, poly_newest, v, 1'b0);
        nw = 1;
      end
      poly_older  = poly_newest;
      poly_newest = v;
      if (poly_count < LAST_IDX) poly_count++;
    end
    if (pin && nw > 0) begin
      words[0].angle = pin_ang;
      words[0].degen = pin_deg;
    end
    for (int k = 0; k < nw; k++) pending_angles.push_back(words[k]);
    vertices_sent++;
  endtask

  task automatic random_polygon(input int nverts, input int mode);
    for (int k = 0; k < nverts; k++)
      send_vertex(pick_coord(mode), pick_coord(mode), k == nverts - 1, 1'b0, 9'd0, 1'b0);
  endtask

  // receiver: random ready bursts, one long hold, always ready at the end
  initial begin
    int span;
    bit take;
    span = 0;
    take = 1'b1;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold)
        out_tready <= 1'b0;
      else if (quiet_phase)
        out_tready <= 1'b1;
      else begin
        if (span == 0) begin
          take = ($urandom_range(0, 2) != 0);
          span = $urandom_range(1, 19);
        end
        out_tready <= take;
        span--;
      end
    end
  end

  // long hold-off so the output buffer fills and in_tready drops
  initial begin
    wait (results_seen >= 30);
    @(posedge clk);
    sink_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    sink_hold = 1'b0;
  end

  // output monitor: each word against the oldest predicted angle
  always @(posedge clk) begin
    pvas_pkg::pvas_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.index = out_tdata[pvas_pkg::IDX_W-1:0];
      got.angle = out_tdata[pvas_pkg::IDX_W +: pvas_pkg::ANG_W];
      got.degen = out_tuser;
      got.done  = out_tlast;
      if (pending_angles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected angle word: index %0d angle %0d degen %0b done %0b",
                   got.index, got.angle, got.degen, got.done);
      end else begin
        want = pending_angles.pop_front();
        if (got.index !== want.index || got.angle !== want.angle ||
            got.degen !== want.degen || got.done !== want.done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("angle word mismatch: exp idx %0d ang %0d dg %0b dn %0b, got idx %0d ang %0d dg %0b dn %0b",
                     want.index, want.angle, want.degen, want.done,
                     got.index, got.angle, got.degen, got.done);
        end
      end
      results_seen++;
      if (got.degen) degen_seen++;
      if (int'(got.index) > top_index) top_index = int'(got.index);
    end
  end

  initial begin
    int rnd_items;
    int nv;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    rst_n       = 1'b0;
    poly_first  = '0;
    poly_second = '0;
    poly_older  = '0;
    poly_newest = '0;
    poly_count  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                  directed_rows[i].pin, directed_rows[i].pin_ang, directed_rows[i].pin_deg);

    // mostly well-formed polygons, some broken short ones
    rnd_items = 0;
    while (rnd_items < 90) begin
      if ($urandom_range(0, 9) == 0)
        nv = $urandom_range(1, 2);
      else
        nv = $urandom_range(3, 10);
      random_polygon(nv, $urandom_range(0, 3));
      rnd_items += nv;
    end

    // no idling from here
    quiet_phase = 1'b1;
    random_polygon(6, 0);
    random_polygon(5, 1);
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d vertices in %0d polygons; checked %0d angle words", vertices_sent,
             polygons_sent, results_seen);
    $display("zero-length edges hit %0d times, highest vertex index %0d", degen_seen,
             top_index);
    if (mismatch_count == 0)
      $display("polygon_vertex_angle_stream_unit verification clean");
    else
      $display("polygon_vertex_angle_stream_unit verification failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("polygon_vertex_angle_stream_unit verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/pvas_pkg.sv
design/pvas_prep.sv
design/pvas_cell.sv
design/pvas_finish.sv
design/polygon_vertex_angle_stream_unit.sv
dv/tb_top.sv
